// File: rtl/ncs_pkg.sv
// Shared types and constants for the navigation cell containment and wall slide block.
// Holds the field widths, register and edge codes, and the payload and pipeline structs.
// Depends on nothing; every other rtl file uses it through scoped names.
package ncs_pkg;

  // Field widths, fixed by the payload structs
  localparam int CoordWidth    = 32;
  localparam int LinkWidth     = 16;
  localparam int NumEdges      = 3;
  localparam int LinksWidth    = NumEdges * LinkWidth;
  localparam int CfgDataWidth  = (LinksWidth > CoordWidth) ? LinksWidth : CoordWidth;
  localparam int CfgIndexWidth = 3;

  // Datapath widths
  localparam int EdgeWidth = CoordWidth + 1;   // vertex difference, edge normal
  localparam int NnWidth   = 2 * EdgeWidth;    // n.n, unsigned
  localparam int QuoWidth  = EdgeWidth;        // quotient bits, one per divider stage
  localparam int RemWidth  = NnWidth;          // partial remainder
  localparam int NumWidth  = RemWidth + QuoWidth;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    CfgVertAX        = 3'd0,
    CfgVertAZ        = 3'd1,
    CfgVertBX        = 3'd2,
    CfgVertBZ        = 3'd3,
    CfgVertCX        = 3'd4,
    CfgVertCZ        = 3'd5,
    CfgNeighborLinks = 3'd6
  } cfg_reg_e;

  // Exit edge codes
  typedef enum logic [1:0] {
    EdgeAB   = 2'd0,
    EdgeBC   = 2'd1,
    EdgeCA   = 2'd2,
    EdgeNone = 2'd3
  } edge_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_z;
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                         inside_res;
    edge_e                        exit_edge;
    logic [LinkWidth-1:0]         neighbor_index;
    logic signed [CoordWidth-1:0] slide_x;
    logic signed [CoordWidth-1:0] slide_y;
    logic signed [CoordWidth-1:0] slide_z;
  } out_t;

  // One divider lane: partial remainder above, numerator / quotient bits below
  typedef struct packed {
    logic [RemWidth-1:0] rem;
    logic [QuoWidth-1:0] low;
  } div_word_t;

  // Per-transaction data that rides alongside the divider
  typedef struct packed {
    edge_e                        exit_edge;
    logic [LinkWidth-1:0]         link;
    logic                         slide_en;
    logic                         neg_x;
    logic                         neg_z;
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
  } div_side_t;

endpackage

// File: rtl/navmesh_cell_containment_slide.sv
// Top level of the navigation cell containment test with wall slide.
// Holds the triangle registers, the edge test and projection stages, and the output register.
// Depends on ncs_pkg and ncs_div_pipe.

// Fully pipelined: one transaction is accepted every clock cycle while the output is not held.
// Each one passes through seven stages for the edge tests, edge choice, k = dir.n, n.n and
// the numerator products, then a restoring divider with one quotient bit per stage, then
// the rounding, saturation and output register.
// The divider depth sets the latency. The whole pipeline holds while a result waits on
// out_ready_i, so in_ready_o drops only then. Triangle registers are meant to be written
// only while no transaction is in flight; the configuration port is always ready.
module navmesh_cell_containment_slide (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ncs_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [ncs_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ncs_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ncs_pkg::out_t                       out_data_o
);

  localparam int Cw   = ncs_pkg::CoordWidth;
  localparam int Lw   = ncs_pkg::LinkWidth;
  localparam int Ne   = ncs_pkg::NumEdges;
  localparam int Ew   = ncs_pkg::EdgeWidth;
  localparam int Pw   = 2 * Ew;          // product of a pair of edge-width values
  localparam int Dw   = Pw + 1;          // edge test dot
  localparam int Kpw  = Cw + Ew;         // dir * normal product
  localparam int Kw   = Kpw + 1;         // k = dir . n, signed
  localparam int Kmw  = Kw - 1;          // |k| when k is positive
  localparam int Khw  = Kmw - Ew;        // upper slice of |k|
  localparam int Nnw  = ncs_pkg::NnWidth;
  localparam int Qw   = ncs_pkg::QuoWidth;
  localparam int Rw   = ncs_pkg::RemWidth;
  localparam int Numw = ncs_pkg::NumWidth;
  localparam int Sw   = Cw + 2;          // slide before saturation

  // Clamp a slide value to the coordinate range
  function automatic logic signed [Cw-1:0] sat_coord(input logic signed [Sw-1:0] v);
    logic signed [Cw-1:0] r;
    r = v[Cw-1:0];
    if (v[Sw-1:Cw-1] != {(Sw-Cw+1){1'b0}} && v[Sw-1:Cw-1] != {(Sw-Cw+1){1'b1}}) begin
      r = v[Sw-1] ? {1'b1, {(Cw-1){1'b0}}} : {1'b0, {(Cw-1){1'b1}}};
    end
    return r;
  endfunction

  logic adv;

  // --------------------------------------------------------------------------
  // Triangle registers
  logic signed [Cw-1:0]   vert_x_q [Ne];
  logic signed [Cw-1:0]   vert_z_q [Ne];
  logic [Ne*Lw-1:0]       links_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < Ne; e++) begin
        vert_x_q[e] <= '0;
        vert_z_q[e] <= '0;
      end
      links_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ncs_pkg::CfgVertAX:        vert_x_q[0] <= cfg_data_i[Cw-1:0];
        ncs_pkg::CfgVertAZ:        vert_z_q[0] <= cfg_data_i[Cw-1:0];
        ncs_pkg::CfgVertBX:        vert_x_q[1] <= cfg_data_i[Cw-1:0];
        ncs_pkg::CfgVertBZ:        vert_z_q[1] <= cfg_data_i[Cw-1:0];
        ncs_pkg::CfgVertCX:        vert_x_q[2] <= cfg_data_i[Cw-1:0];
        ncs_pkg::CfgVertCZ:        vert_z_q[2] <= cfg_data_i[Cw-1:0];
        ncs_pkg::CfgNeighborLinks: links_q     <= cfg_data_i[Ne*Lw-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Stage 1: edge normals and position relative to each start vertex
  logic                 s1_valid_q;
  logic signed [Ew-1:0] s1_nx_q [Ne];
  logic signed [Ew-1:0] s1_nz_q [Ne];
  logic signed [Ew-1:0] s1_rx_q [Ne];
  logic signed [Ew-1:0] s1_rz_q [Ne];
  logic signed [Cw-1:0] s1_dx_q, s1_dy_q, s1_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < Ne; e++) begin
        // normal (-(E.z - S.z), E.x - S.x), end vertex is the next one around
        s1_nx_q[e] <= Ew'(vert_z_q[e]) - Ew'(vert_z_q[(e == Ne - 1) ? 0 : e + 1]);
        s1_nz_q[e] <= Ew'(vert_x_q[(e == Ne - 1) ? 0 : e + 1]) - Ew'(vert_x_q[e]);
        s1_rx_q[e] <= Ew'(in_data_i.pos_x) - Ew'(vert_x_q[e]);
        s1_rz_q[e] <= Ew'(in_data_i.pos_z) - Ew'(vert_z_q[e]);
      end
      s1_dx_q <= in_data_i.dir_x;
      s1_dy_q <= in_data_i.dir_y;
      s1_dz_q <= in_data_i.dir_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: edge test products
  logic                 s2_valid_q;
  logic signed [Pw-1:0] s2_px_q [Ne];
  logic signed [Pw-1:0] s2_pz_q [Ne];
  logic signed [Ew-1:0] s2_nx_q [Ne];
  logic signed [Ew-1:0] s2_nz_q [Ne];
  logic signed [Cw-1:0] s2_dx_q, s2_dy_q, s2_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < Ne; e++) begin
        s2_px_q[e] <= s1_rx_q[e] * s1_nx_q[e];
        s2_pz_q[e] <= s1_rz_q[e] * s1_nz_q[e];
        s2_nx_q[e] <= s1_nx_q[e];
        s2_nz_q[e] <= s1_nz_q[e];
      end
      s2_dx_q <= s1_dx_q;
      s2_dy_q <= s1_dy_q;
      s2_dz_q <= s1_dz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum the dots, pick the first edge that sees the point outside
  logic                 s3_valid_q;
  ncs_pkg::edge_e       s3_edge_q, s3_edge_d;
  logic signed [Ew-1:0] s3_nx_q, s3_nx_d;
  logic signed [Ew-1:0] s3_nz_q, s3_nz_d;
  logic [Lw-1:0]        s3_link_q, s3_link_d;
  logic signed [Cw-1:0] s3_dx_q, s3_dy_q, s3_dz_q;
  logic signed [Dw-1:0] dot [Ne];
  logic [Ne-1:0]        outside;

  always_comb begin
    for (int e = 0; e < Ne; e++) begin
      dot[e]     = Dw'(s2_px_q[e]) + Dw'(s2_pz_q[e]);
      outside[e] = !dot[e][Dw-1] && (dot[e] != '0);
    end
    // lowest edge wins
    s3_edge_d = ncs_pkg::EdgeNone;
    s3_nx_d   = '0;
    s3_nz_d   = '0;
    s3_link_d = '1;
    if (outside[2]) begin
      s3_edge_d = ncs_pkg::EdgeCA;
      s3_nx_d   = s2_nx_q[2];
      s3_nz_d   = s2_nz_q[2];
      s3_link_d = links_q[2*Lw +: Lw];
    end
    if (outside[1]) begin
      s3_edge_d = ncs_pkg::EdgeBC;
      s3_nx_d   = s2_nx_q[1];
      s3_nz_d   = s2_nz_q[1];
      s3_link_d = links_q[Lw +: Lw];
    end
    if (outside[0]) begin
      s3_edge_d = ncs_pkg::EdgeAB;
      s3_nx_d   = s2_nx_q[0];
      s3_nz_d   = s2_nz_q[0];
      s3_link_d = links_q[0 +: Lw];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_edge_q <= s3_edge_d;
      s3_nx_q   <= s3_nx_d;
      s3_nz_q   <= s3_nz_d;
      s3_link_q <= s3_link_d;
      s3_dx_q   <= s2_dx_q;
      s3_dy_q   <= s2_dy_q;
      s3_dz_q   <= s2_dz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: products for k = dir.n and n.n
  logic                  s4_valid_q;
  logic signed [Kpw-1:0] s4_kx_q, s4_kz_q;
  logic signed [Pw-1:0]  s4_nxx_q, s4_nzz_q;
  ncs_pkg::edge_e        s4_edge_q;
  logic signed [Ew-1:0]  s4_nx_q, s4_nz_q;
  logic [Lw-1:0]         s4_link_q;
  logic signed [Cw-1:0]  s4_dx_q, s4_dy_q, s4_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_kx_q   <= s3_dx_q * s3_nx_q;
      s4_kz_q   <= s3_dz_q * s3_nz_q;
      s4_nxx_q  <= s3_nx_q * s3_nx_q;
      s4_nzz_q  <= s3_nz_q * s3_nz_q;
      s4_edge_q <= s3_edge_q;
      s4_nx_q   <= s3_nx_q;
      s4_nz_q   <= s3_nz_q;
      s4_link_q <= s3_link_q;
      s4_dx_q   <= s3_dx_q;
      s4_dy_q   <= s3_dy_q;
      s4_dz_q   <= s3_dz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: k, n.n, slide decision, normal magnitudes
  logic                 s5_valid_q;
  logic signed [Kw-1:0] k_sum;
  logic                 s5_slide_en_q, s5_slide_en_d;
  logic [Kmw-1:0]       s5_kmag_q;
  logic [Nnw-1:0]       s5_nn_q, s5_nn_d;
  logic [Ew-1:0]        s5_nxm_q, s5_nxm_d;
  logic [Ew-1:0]        s5_nzm_q, s5_nzm_d;
  logic                 s5_neg_x_q, s5_neg_z_q;
  ncs_pkg::edge_e       s5_edge_q;
  logic [Lw-1:0]        s5_link_q;
  logic signed [Cw-1:0] s5_dx_q, s5_dy_q, s5_dz_q;

  always_comb begin
    k_sum         = Kw'(s4_kx_q) + Kw'(s4_kz_q);
    s5_slide_en_d = (s4_edge_q != ncs_pkg::EdgeNone) && !k_sum[Kw-1] && (k_sum != '0);
    s5_nn_d       = Nnw'($unsigned(s4_nxx_q)) + Nnw'($unsigned(s4_nzz_q));
    s5_nxm_d      = s4_nx_q[Ew-1] ? Ew'(-s4_nx_q) : Ew'(s4_nx_q);
    s5_nzm_d      = s4_nz_q[Ew-1] ? Ew'(-s4_nz_q) : Ew'(s4_nz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (adv) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_slide_en_q <= s5_slide_en_d;
      s5_kmag_q     <= k_sum[Kmw-1:0];
      s5_nn_q       <= s5_nn_d;
      s5_nxm_q      <= s5_nxm_d;
      s5_nzm_q      <= s5_nzm_d;
      s5_neg_x_q    <= s4_nx_q[Ew-1];
      s5_neg_z_q    <= s4_nz_q[Ew-1];
      s5_edge_q     <= s4_edge_q;
      s5_link_q     <= s4_link_q;
      s5_dx_q       <= s4_dx_q;
      s5_dy_q       <= s4_dy_q;
      s5_dz_q       <= s4_dz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: |n| * |k| as two partial products per lane
  logic                  s6_valid_q;
  logic [2*Ew-1:0]       s6_xl_q, s6_zl_q;
  logic [Ew+Khw-1:0]     s6_xh_q, s6_zh_q;
  logic [Nnw-1:0]        s6_nn_q;
  ncs_pkg::div_side_t    s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (adv) begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_xl_q <= s5_nxm_q * s5_kmag_q[Ew-1:0];
      s6_xh_q <= s5_nxm_q * s5_kmag_q[Kmw-1:Ew];
      s6_zl_q <= s5_nzm_q * s5_kmag_q[Ew-1:0];
      s6_zh_q <= s5_nzm_q * s5_kmag_q[Kmw-1:Ew];
      s6_nn_q <= s5_nn_q;
      s6_side_q.exit_edge <= s5_edge_q;
      s6_side_q.link      <= s5_link_q;
      s6_side_q.slide_en  <= s5_slide_en_q;
      s6_side_q.neg_x     <= s5_neg_x_q;
      s6_side_q.neg_z     <= s5_neg_z_q;
      s6_side_q.dir_x     <= s5_dx_q;
      s6_side_q.dir_y     <= s5_dy_q;
      s6_side_q.dir_z     <= s5_dz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: combine partial products into the divider numerators
  logic               s7_valid_q;
  logic [Numw-1:0]    s7_num_x_q, s7_num_z_q;
  logic [Nnw-1:0]     s7_nn_q;
  ncs_pkg::div_side_t s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (adv) begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_num_x_q <= Numw'(s6_xl_q) + (Numw'(s6_xh_q) << Ew);
      s7_num_z_q <= Numw'(s6_zl_q) + (Numw'(s6_zh_q) << Ew);
      s7_nn_q    <= s6_nn_q;
      s7_side_q  <= s6_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: n.x*k / n.n and n.z*k / n.n
  ncs_pkg::div_word_t div_x_in, div_z_in, div_x_out, div_z_out;
  ncs_pkg::div_side_t div_side_out;
  logic               div_valid_out;
  logic [Rw-1:0]      div_den_out;

  assign div_x_in.rem = s7_num_x_q[Numw-1:Qw];
  assign div_x_in.low = s7_num_x_q[Qw-1:0];
  assign div_z_in.rem = s7_num_z_q[Numw-1:Qw];
  assign div_z_in.low = s7_num_z_q[Qw-1:0];

  ncs_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s7_valid_q),
    .side_i  (s7_side_q),
    .x_i     (div_x_in),
    .z_i     (div_z_in),
    .den_i   (s7_nn_q),
    .valid_o (div_valid_out),
    .side_o  (div_side_out),
    .x_o     (div_x_out),
    .z_o     (div_z_out),
    .den_o   (div_den_out)
  );

  // --------------------------------------------------------------------------
  // Final: round half away from zero, apply sign, subtract, saturate
  logic                 round_x, round_z;
  logic [Qw-1:0]        qr_x, qr_z;
  logic signed [Sw-1:0] rm_x, rm_z, sl_x, sl_z;
  ncs_pkg::out_t        out_d, out_q;
  logic                 out_valid_q;

  always_comb begin
    round_x = {div_x_out.rem, 1'b0} >= {1'b0, div_den_out};
    round_z = {div_z_out.rem, 1'b0} >= {1'b0, div_den_out};
    qr_x    = div_x_out.low + Qw'(round_x);
    qr_z    = div_z_out.low + Qw'(round_z);
    rm_x    = Sw'(qr_x);
    rm_z    = Sw'(qr_z);
    if (div_side_out.neg_x) begin
      rm_x = -rm_x;
    end
    if (div_side_out.neg_z) begin
      rm_z = -rm_z;
    end
    sl_x = Sw'(div_side_out.dir_x) - rm_x;
    sl_z = Sw'(div_side_out.dir_z) - rm_z;

    out_d.inside_res     = (div_side_out.exit_edge == ncs_pkg::EdgeNone);
    out_d.exit_edge      = div_side_out.exit_edge;
    out_d.neighbor_index = div_side_out.link;
    out_d.slide_x        = div_side_out.slide_en ? sat_coord(sl_x) : div_side_out.dir_x;
    out_d.slide_y        = div_side_out.dir_y;
    out_d.slide_z        = div_side_out.slide_en ? sat_coord(sl_z) : div_side_out.dir_z;
  end

  // whole pipeline moves unless a finished result is held
  assign adv = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A positive edge test needs a non-degenerate edge
  a_exit_edge_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s3_edge_q != ncs_pkg::EdgeNone |-> (s3_nx_q != '0 || s3_nz_q != '0))
    else $error("exit edge chosen with zero normal");

  // Sliding only happens when the point left through an edge
  a_slide_needs_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q && s5_slide_en_q |-> s5_edge_q != ncs_pkg::EdgeNone && s5_nn_q != '0)
    else $error("slide requested without exit edge");

  // An inside result carries no edge and no neighbor
  a_inside_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.inside_res |->
      out_data_o.exit_edge == ncs_pkg::EdgeNone && out_data_o.neighbor_index == '1)
    else $error("inside result with exit edge or neighbor");
`endif

endmodule

// File: rtl/ncs_div_pipe.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Carries a sideband struct with each transaction and stalls as a whole on en_i.
// Depends on ncs_pkg.
module ncs_div_pipe (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  ncs_pkg::div_side_t               side_i,
  input  ncs_pkg::div_word_t               x_i,
  input  ncs_pkg::div_word_t               z_i,
  input  logic [ncs_pkg::RemWidth-1:0]     den_i,
  output logic                             valid_o,
  output ncs_pkg::div_side_t               side_o,
  output ncs_pkg::div_word_t               x_o,
  output ncs_pkg::div_word_t               z_o,
  output logic [ncs_pkg::RemWidth-1:0]     den_o
);

  localparam int Stages = ncs_pkg::QuoWidth;
  localparam int Rw     = ncs_pkg::RemWidth;
  localparam int Qw     = ncs_pkg::QuoWidth;

  // Shift one numerator bit into the remainder, subtract the divisor if it fits
  function automatic ncs_pkg::div_word_t div_step(input ncs_pkg::div_word_t w,
                                                  input logic [Rw-1:0] den);
    logic [Rw-1:0]      shifted;
    ncs_pkg::div_word_t r;
    shifted = {w.rem[Rw-2:0], w.low[Qw-1]};
    r.low   = {w.low[Qw-2:0], 1'b0};
    r.rem   = shifted;
    if (shifted >= den) begin
      r.rem    = shifted - den;
      r.low[0] = 1'b1;
    end
    return r;
  endfunction

  logic               valid_q [Stages];
  ncs_pkg::div_side_t side_q  [Stages];
  ncs_pkg::div_word_t x_q     [Stages];
  ncs_pkg::div_word_t z_q     [Stages];
  logic [Rw-1:0]      den_q   [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_step
    logic               v_in;
    ncs_pkg::div_side_t side_in;
    ncs_pkg::div_word_t x_in;
    ncs_pkg::div_word_t z_in;
    logic [Rw-1:0]      den_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign x_in    = x_i;
      assign z_in    = z_i;
      assign den_in  = den_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign side_in = side_q[s-1];
      assign x_in    = x_q[s-1];
      assign z_in    = z_q[s-1];
      assign den_in  = den_q[s-1];
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    // one quotient bit per lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        x_q[s]    <= div_step(x_in, den_in);
        z_q[s]    <= div_step(z_in, den_in);
        den_q[s]  <= den_in;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign side_o  = side_q[Stages-1];
  assign x_o     = x_q[Stages-1];
  assign z_o     = z_q[Stages-1];
  assign den_o   = den_q[Stages-1];

`ifndef SYNTHESIS
  // The numerator head must start below the divisor, or quotient bits are lost
  a_head_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && side_i.slide_en |-> x_i.rem < den_i)
    else $error("x numerator head not below divisor");

  a_head_z_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && side_i.slide_en |-> z_i.rem < den_i)
    else $error("z numerator head not below divisor");

  // The removed part never exceeds the direction length, so the top bit stays clear
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && side_o.slide_en |-> !x_o.low[Qw-1] && !z_o.low[Qw-1])
    else $error("quotient out of coordinate range");
`endif

endmodule

// File: sim/ncs_slide_checker.sv
`timescale 1ns / 1ps
// Checker for the navigation cell containment and wall slide block: watches the
// register, query and result channels, predicts each result and compares it.
// Depends on ncs_pkg for the payload structs, register indexes and edge codes.
module ncs_slide_checker
  import ncs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  in_t                      in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  out_t                     out_data_i,
  output int                       pending_o,
  output int                       fail_count_o
);

  localparam int ReportLimit = 100;
  localparam logic signed [127:0] SlideMax = (128'sd1 <<< (CoordWidth - 1)) - 128'sd1;
  localparam logic signed [127:0] SlideMin = -(128'sd1 <<< (CoordWidth - 1));

  // Local copy of the triangle registers
  logic signed [CoordWidth-1:0] corner_x [NumEdges];
  logic signed [CoordWidth-1:0] corner_z [NumEdges];
  logic [LinksWidth-1:0]        links;

  out_t expected_slides [$];
  out_t want;
  int   mismatches = 0;

  assign fail_count_o = mismatches;

  // One line per mismatch, capped to keep the log readable
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (mismatches < ReportLimit)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  // d - round(num / nn), ties away from zero, saturated to the coordinate range
  function automatic logic [CoordWidth-1:0] slid_coord(logic signed [127:0] d,
                                                        logic signed [127:0] num,
                                                        logic signed [127:0] nn);
    logic [127:0]        mag;
    logic [127:0]        quo;
    logic [127:0]        rem;
    logic signed [127:0] v;
    mag = (num < 0) ? -num : num;
    quo = mag / nn;
    rem = mag % nn;
    if ((rem << 1) >= nn) quo = quo + 1;
    v = (num < 0) ? d + $signed(quo) : d - $signed(quo);
    if (v > SlideMax) v = SlideMax;
    if (v < SlideMin) v = SlideMin;
    return v[CoordWidth-1:0];
  endfunction

  // Edge tests in order AB, BC, CA; first positive side test is the exit edge
  function automatic out_t predict_containment(in_t q);
    logic signed [127:0] vx [NumEdges];
    logic signed [127:0] vz [NumEdges];
    logic signed [127:0] px, pz, dx, dz, nx, nz, side, k, nn;
    out_t r;
    int   e;
    int   nxt;
    bit   found;
    px = $signed(q.pos_x);
    pz = $signed(q.pos_z);
    dx = $signed(q.dir_x);
    dz = $signed(q.dir_z);
    for (e = 0; e < NumEdges; e++) begin
      vx[e] = corner_x[e];
      vz[e] = corner_z[e];
    end
    r.inside_res     = 1'b1;
    r.exit_edge      = EdgeNone;
    r.neighbor_index = '1;
    r.slide_x        = q.dir_x;
    r.slide_y        = q.dir_y;
    r.slide_z        = q.dir_z;
    found            = 1'b0;
    for (e = 0; e < NumEdges; e++) begin
      nxt  = (e + 1) % NumEdges;
      nx   = -(vz[nxt] - vz[e]);
      nz   = vx[nxt] - vx[e];
      side = (px - vx[e]) * nx + (pz - vz[e]) * nz;
      if (!found && side > 0) begin
        found            = 1'b1;
        r.inside_res     = 1'b0;
        r.exit_edge      = edge_e'(e);
        r.neighbor_index = links[e*LinkWidth +: LinkWidth];
        k = dx * nx + dz * nz;
        // only a direction heading out across the wall gets slid
        if (k > 0) begin
          nn        = nx * nx + nz * nz;
          r.slide_x = slid_coord(dx, nx * k, nn);
          r.slide_z = slid_coord(dz, nz * k, nn);
        end
      end
    end
    return r;
  endfunction

  // Results first, then new queries, then register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEdges; i++) begin
        corner_x[i] = '0;
        corner_z[i] = '0;
      end
      links = '1;
      expected_slides.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_slides.size() == 0) begin
          report_mismatch("result with no transaction outstanding", '0, '0);
        end else begin
          want = expected_slides.pop_front();
          if (out_data_i.inside_res !== want.inside_res)
            report_mismatch("inside_res", out_data_i.inside_res, want.inside_res);
          if (out_data_i.exit_edge !== want.exit_edge)
            report_mismatch("exit_edge", out_data_i.exit_edge, want.exit_edge);
          if (out_data_i.neighbor_index !== want.neighbor_index)
            report_mismatch("neighbor_index", out_data_i.neighbor_index,
                            want.neighbor_index);
          if (out_data_i.slide_x !== want.slide_x)
            report_mismatch("slide_x", out_data_i.slide_x, want.slide_x);
          if (out_data_i.slide_y !== want.slide_y)
            report_mismatch("slide_y", out_data_i.slide_y, want.slide_y);
          if (out_data_i.slide_z !== want.slide_z)
            report_mismatch("slide_z", out_data_i.slide_z, want.slide_z);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_slides.push_back(predict_containment(in_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgVertAX:        corner_x[0] = cfg_data_i[CoordWidth-1:0];
          CfgVertAZ:        corner_z[0] = cfg_data_i[CoordWidth-1:0];
          CfgVertBX:        corner_x[1] = cfg_data_i[CoordWidth-1:0];
          CfgVertBZ:        corner_z[1] = cfg_data_i[CoordWidth-1:0];
          CfgVertCX:        corner_x[2] = cfg_data_i[CoordWidth-1:0];
          CfgVertCZ:        corner_z[2] = cfg_data_i[CoordWidth-1:0];
          CfgNeighborLinks: links = cfg_data_i[LinksWidth-1:0];
          default: ;  // unmapped index, write dropped
        endcase
      end
      pending_o <= expected_slides.size();
    end
  end

endmodule

// File: sim/tb_navmesh_cell_containment_slide.sv
`timescale 1ns / 1ps
// Testbench top for navmesh_cell_containment_slide: clock, reset, register and query
// stimulus with random idling, result back-pressure, watchdog and the verdict.
// Depends on ncs_pkg, the block and ncs_slide_checker.
module tb_navmesh_cell_containment_slide;
  import ncs_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int TailCycles   = 60;
  localparam int RandomPhases = 13;
  localparam int PhaseItems   = 100;
  localparam int PadWidth     = CfgDataWidth - CoordWidth;
  localparam int One          = 65536;  // 1.0 in Q16.16

  localparam logic [CoordWidth-1:0]    CoordMax    = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam logic [CoordWidth-1:0]    CoordMin    = {1'b1, {(CoordWidth - 1){1'b0}}};
  localparam logic [CfgIndexWidth-1:0] CfgUnmapped = '1;

  // Value shapes for random coordinates
  localparam int unsigned DrawFull    = 0;
  localparam int unsigned DrawScaled  = 1;
  localparam int unsigned DrawExtreme = 2;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  in_t                      in_data_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  out_t                     out_data_o;

  int pending;
  int fail_count;
  int unsigned quiet_cycles;
  bit steady;

  // Stimulus-side copy of the current triangle, for aiming queries
  logic signed [63:0] tri_x [NumEdges];
  logic signed [63:0] tri_z [NumEdges];

  always #2 clk_i = ~clk_i;

  navmesh_cell_containment_slide dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  ncs_slide_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Watchdog: too many cycles without any transaction ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("navmesh_cell_containment_slide: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall before each result, none in steady stretches
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(7, 0);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [CoordWidth-1:0] draw_coord(int unsigned shape);
    logic [CoordWidth-1:0] raw;
    raw = $urandom();
    case (shape)
      DrawScaled: return $signed(raw) >>> $urandom_range(CoordWidth - 1, 0);
      DrawExtreme: begin
        case ($urandom_range(4, 0))
          0:       return CoordMin;
          1:       return CoordMax;
          2:       return '0;
          3:       return '1;
          default: return CoordWidth'(1);
        endcase
      end
      default: return raw;
    endcase
  endfunction

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Vertex writes carry junk above the coordinate bits
  task automatic load_triangle(logic [CoordWidth-1:0] ax, logic [CoordWidth-1:0] az,
                               logic [CoordWidth-1:0] bx, logic [CoordWidth-1:0] bz,
                               logic [CoordWidth-1:0] cx, logic [CoordWidth-1:0] cz,
                               logic [LinksWidth-1:0] nbr);
    write_reg(CfgVertAX, {PadWidth'($urandom()), ax});
    write_reg(CfgVertAZ, {PadWidth'($urandom()), az});
    write_reg(CfgVertBX, {PadWidth'($urandom()), bx});
    write_reg(CfgVertBZ, {PadWidth'($urandom()), bz});
    write_reg(CfgVertCX, {PadWidth'($urandom()), cx});
    write_reg(CfgVertCZ, {PadWidth'($urandom()), cz});
    write_reg(CfgNeighborLinks, CfgDataWidth'(nbr));
    if ($urandom_range(2, 0) == 0)
      write_reg(CfgUnmapped, CfgDataWidth'({$urandom(), $urandom()}));
    cfg_valid_i <= 1'b0;
    tri_x[0] = $signed(ax);
    tri_z[0] = $signed(az);
    tri_x[1] = $signed(bx);
    tri_z[1] = $signed(bz);
    tri_x[2] = $signed(cx);
    tri_z[2] = $signed(cz);
  endtask

  task automatic load_random_triangle(int unsigned shape);
    logic [CoordWidth-1:0] v [6];
    logic [LinksWidth-1:0] nbr;
    for (int i = 0; i < 6; i++) v[i] = draw_coord(shape);
    // sometimes collapse edge AB to a point
    if ($urandom_range(4, 0) == 0) begin
      v[2] = v[0];
      v[3] = v[1];
    end
    case ($urandom_range(3, 0))
      0:       nbr = '1;
      1:       nbr = '0;
      default: nbr = LinksWidth'({$urandom(), $urandom()});
    endcase
    load_triangle(v[0], v[1], v[2], v[3], v[4], v[5], nbr);
  endtask

  task automatic send_query(logic [CoordWidth-1:0] px, logic [CoordWidth-1:0] pz,
                            logic [CoordWidth-1:0] dx, logic [CoordWidth-1:0] dy,
                            logic [CoordWidth-1:0] dz);
    in_t         q;
    int unsigned gap;
    q.pos_x = px;
    q.pos_z = pz;
    q.dir_x = dx;
    q.dir_y = dy;
    q.dir_z = dz;
    gap = steady ? 0 : $urandom_range(7, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Queries aimed around the triangle, with some plain noise
  task automatic send_random_query();
    logic signed [63:0] px, pz;
    int unsigned        a, b, shape;
    a     = $urandom_range(2, 0);
    b     = $urandom_range(2, 0);
    shape = $urandom_range(7, 0);
    px    = tri_x[a];
    pz    = tri_z[a];
    if (shape == 0) begin
      px = $signed(draw_coord(DrawFull));
      pz = $signed(draw_coord(DrawFull));
    end else if (shape < 3) begin
      px = (tri_x[0] + tri_x[1] + tri_x[2]) / 3;
      pz = (tri_z[0] + tri_z[1] + tri_z[2]) / 3;
    end else if (shape < 6) begin
      px = (px + tri_x[b]) >>> 1;
      pz = (pz + tri_z[b]) >>> 1;
    end
    if (shape != 0) begin
      px = px + $signed(draw_coord(DrawScaled));
      pz = pz + $signed(draw_coord(DrawScaled));
    end
    send_query(px[CoordWidth-1:0], pz[CoordWidth-1:0],
               draw_coord($urandom_range(2, 0)), draw_coord(DrawFull),
               draw_coord($urandom_range(2, 0)));
  endtask

  // Hold off new queries until every outstanding result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    steady      = 1'b0;
    for (int i = 0; i < NumEdges; i++) begin
      tri_x[i] = 0;
      tri_z[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset triangle: all edges collapsed, every point is inside
    send_query(CoordMin, CoordMax, CoordMax, CoordMin, CoordMin);
    send_query(CoordMax, CoordMin, CoordMin, CoordMax, CoordMax);

    // Unit-scale triangle, edge normals AB (2,1), BC (-1,-4), CA (-1,3)
    drain_results();
    load_triangle(0, 0, One, -2 * One, -3 * One, -One, 48'h3333_2222_1111);
    send_query(-One / 2, -One, One, One, One);              // inside
    send_query(One / 2, -One, -One, 0, One);                // on the AB line
    send_query(One, -2 * One, One, -One, One);              // on vertex B
    send_query(10 * One, 0, CoordMax, CoordMin, CoordMin + 1);  // slide saturates
    send_query(10 * One, 0, CoordMin, CoordMax, CoordMin);  // heading inward
    send_query(10 * One, 0, One, 0, -2 * One);              // along the wall
    send_query(10 * One, 0, 1, 1, 0);                       // tiny outward step
    send_query(0, -5 * One, 0, CoordMax, -One);             // out across BC
    send_query(-3 * One, One, -One, 0, 0);                  // out across CA
    send_query(CoordMin, CoordMin, CoordMax, 0, CoordMax);
    send_query(CoordMax, CoordMax, CoordMin, '1, CoordMin);

    // Raw-unit triangle where the projection lands exactly on a half
    drain_results();
    load_triangle(0, 0, 1, -1, -1, -1, 48'h0000_FFFF_0000);
    send_query(5, 0, 1, 7, 0);    // positive tie
    send_query(-5, 5, 0, 0, 1);   // negative tie
    send_query(3, 3, CoordMax, CoordMax, CoordMax);

    // Collapsed edge AB next to a real edge
    drain_results();
    load_triangle(One, One, One, One, -One, 2 * One, '1);
    send_query(CoordMax, CoordMax, CoordMin, CoordMin, CoordMax);
    send_query(0, 0, One, One, One);

    // Random triangles, each with a batch of aimed queries
    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain_results();
      steady = (phase % 4 == 2);
      load_random_triangle(phase == 0 ? DrawExtreme : phase % 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 5 && n == PhaseItems / 2) drain_results();
        send_random_query();
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("navmesh_cell_containment_slide: match");
    else
      $display("navmesh_cell_containment_slide: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/ncs_pkg.sv
rtl/ncs_div_pipe.sv
rtl/navmesh_cell_containment_slide.sv
sim/ncs_slide_checker.sv
sim/tb_navmesh_cell_containment_slide.sv
